>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/pfcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcs_pkg
// shared types, codes and constants of the flash command sequencer
// ----------------------------------------------------------------------------
package pfcs_pkg;

  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int TO_W         = 25;
  localparam int STEP_W       = 3;
  localparam int ADDR_BITS    = 16;
  localparam int SECTOR_SHIFT = 12;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [TO_W-1:0] TIMEOUT_RESET = 25'd17170000;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] SECTOR_MASK =
    ADDR_MASK & ~ADDR_W'((64'd1 << SECTOR_SHIFT) - 64'd1);

  localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = 16'h5555;
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = 16'h2AAA;
  localparam logic [DATA_W-1:0] UNLOCK_DATA1 = 8'hAA;
  localparam logic [DATA_W-1:0] UNLOCK_DATA2 = 8'h55;
  localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 8'h80;
  localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;

  typedef enum logic [2:0] {
    FN_READ     = 3'd0,
    FN_PROGRAM  = 3'd1,
    FN_SECT_ERA = 3'd2,
    FN_CHIP_ERA = 3'd3,
    FN_POLL     = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    K_WRITE   = 3'd0,
    K_READ    = 3'd1,
    K_DONE    = 3'd2,
    K_BUSY    = 3'd3,
    K_TIMEOUT = 3'd4,
    K_REJECT  = 3'd5,
    K_IDLE    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    SEQ_SINGLE = 2'd0,
    SEQ_PROG   = 2'd1,
    SEQ_ERASE  = 2'd2
  } seq_t;

  // queued command: final write (or single result) address/data
  typedef struct packed {
    seq_t              seq;
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } out_item_t;

  // bus cycle for a given step of a queued command
  function automatic out_item_t seq_item(cmd_t cmd, logic [STEP_W-1:0] step);
    out_item_t it;
    it.kind = K_WRITE;
    it.addr = cmd.addr;
    it.data = cmd.data;
    it.last = 1'b0;
    unique case (cmd.seq)
      SEQ_SINGLE: begin
        it.kind = cmd.kind;
        it.last = 1'b1;
      end
      SEQ_PROG: begin
        unique case (step) inside
          3'd0: begin
            it.addr = UNLOCK_ADDR1;
            it.data = UNLOCK_DATA1;
          end
          3'd1: begin
            it.addr = UNLOCK_ADDR2;
            it.data = UNLOCK_DATA2;
          end
          3'd2: begin
            it.addr = UNLOCK_ADDR1;
            it.data = CMD_PROGRAM;
          end
          default: it.last = 1'b1;
        endcase
      end
      SEQ_ERASE: begin
        unique case (step) inside
          3'd0, 3'd3: begin
            it.addr = UNLOCK_ADDR1;
            it.data = UNLOCK_DATA1;
          end
          3'd1, 3'd4: begin
            it.addr = UNLOCK_ADDR2;
            it.data = UNLOCK_DATA2;
          end
          3'd2: begin
            it.addr = UNLOCK_ADDR1;
            it.data = CMD_ERASE_SETUP;
          end
          default: it.last = 1'b1;
        endcase
      end
      default: it.last = 1'b1;
    endcase
    return it;
  endfunction

endpackage

>>> sv/pfcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcs_front
// accepts requests, tracks busy/poll state and queues one command per known func
// ----------------------------------------------------------------------------
module pfcs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [23:0]                  s_tdata,     // address[15:0], data[23:16]
  input  logic [2:0]                   s_tuser,     // func[2:0]
  input  logic                         cfg_wr_en,
  input  logic [pfcs_pkg::TO_W-1:0]    cfg_wr_data,
  input  logic                         q_full,
  output logic                         push,
  output pfcs_pkg::cmd_t               cmd
);
  import pfcs_pkg::*;

  logic              busy;
  logic              expected_msb;
  logic [TO_W-1:0]   poll_count;
  logic [TO_W-1:0]   poll_timeout;

  logic              busy_next;
  logic              expected_msb_next;
  logic [TO_W-1:0]   poll_count_next;
  logic [TO_W-1:0]   count_inc;
  logic              accept;
  logic [ADDR_W-1:0] in_addr;
  logic [DATA_W-1:0] in_data;
  func_t             func;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign in_addr   = s_tdata[15:0] & ADDR_MASK;
  assign in_data   = s_tdata[23:16];
  assign func      = func_t'(s_tuser);
  assign count_inc = poll_count + 1'b1;

  always_comb begin
    busy_next         = busy;
    expected_msb_next = expected_msb;
    poll_count_next   = poll_count;
    push              = 1'b1;
    cmd.seq           = SEQ_SINGLE;
    cmd.kind          = K_REJECT;
    cmd.addr          = '0;
    cmd.data          = '0;
    unique case (func)
      FN_POLL: begin
        if (!busy) begin
          cmd.kind = K_IDLE;
        end else if (in_data[DATA_W-1] == expected_msb) begin
          cmd.kind        = K_DONE;
          busy_next       = 1'b0;
          poll_count_next = '0;
        end else if (count_inc >= poll_timeout) begin
          cmd.kind        = K_TIMEOUT;
          busy_next       = 1'b0;
          poll_count_next = '0;
        end else begin
          cmd.kind        = K_BUSY;
          poll_count_next = count_inc;
        end
      end
      FN_READ: begin
        if (!busy) begin
          cmd.kind = K_READ;
          cmd.addr = in_addr;
        end
      end
      FN_PROGRAM: begin
        if (!busy) begin
          cmd.seq           = SEQ_PROG;
          cmd.kind          = K_WRITE;
          cmd.addr          = in_addr;
          cmd.data          = in_data;
          busy_next         = 1'b1;
          expected_msb_next = in_data[DATA_W-1];
          poll_count_next   = '0;
        end
      end
      FN_SECT_ERA: begin
        if (!busy) begin
          cmd.seq           = SEQ_ERASE;
          cmd.kind          = K_WRITE;
          cmd.addr          = in_addr & SECTOR_MASK;
          cmd.data          = CMD_SECTOR_ERASE;
          busy_next         = 1'b1;
          expected_msb_next = 1'b1;
          poll_count_next   = '0;
        end
      end
      FN_CHIP_ERA: begin
        if (!busy) begin
          cmd.seq           = SEQ_ERASE;
          cmd.kind          = K_WRITE;
          cmd.addr          = UNLOCK_ADDR1;
          cmd.data          = CMD_CHIP_ERASE;
          busy_next         = 1'b1;
          expected_msb_next = 1'b1;
          poll_count_next   = '0;
        end
      end
      // unused function codes are dropped
      default: push = 1'b0;
    endcase
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      expected_msb <= 1'b0;
      poll_count   <= '0;
      poll_timeout <= TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        poll_timeout <= cfg_wr_data;
      end
      if (accept) begin
        busy         <= busy_next;
        expected_msb <= expected_msb_next;
        poll_count   <= poll_count_next;
      end
    end
  end

endmodule

>>> sv/pfcs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcs_fifo
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module pfcs_fifo #(
  parameter int DEPTH = pfcs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pfcs_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output pfcs_pkg::cmd_t head
);
  import pfcs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/pfcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcs_back
// steps through the bus cycles of the queued command into an output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfcs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  pfcs_pkg::cmd_t head,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [23:0]    m_tdata,   // bus_address[15:0], bus_data[23:16]
  output logic [2:0]     m_tuser,   // kind[2:0]
  output logic           m_tlast
);
  import pfcs_pkg::*;

  logic [STEP_W-1:0] step;
  out_item_t         item;
  logic              load;

  assign item = seq_item(head, step);
  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop  = load && item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        step     <= item.last ? '0 : step + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {item.data, item.addr};
      m_tuser <= item.kind;
      m_tlast <= item.last;
    end
  end

  `ASSERT_IMPLIES(a_step_range, clk, rst, 1'b1, step <= 3'd5)
  `ASSERT_IMPLIES(a_step_has_cmd, clk, rst, step != '0, head_valid)
  `ASSERT_NEXT(a_last_restarts, clk, rst, load && item.last, step == '0)

endmodule

>>> sv/parallel_flash_command_sequencer.sv
`timescale 1ns / 1ps
// requests enter the command queue one per clock while it has room, then the back-end
//   output register; throughput: one result per clock while m_tready is high; a read
//   or status is one bus cycle, program/erase add unlocks, set by the back-end step counter
// reset: synchronous, active high; clears busy/poll state, empties the queue,
//   poll_timeout returns to 17170000
// ----------------------------------------------------------------------------
// parallel_flash_command_sequencer
// jedec-style nor flash command sequencer with dq7 data polling
// ----------------------------------------------------------------------------
module parallel_flash_command_sequencer #(
  parameter int QUEUE_DEPTH = pfcs_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [23:0]               s_tdata,     // address[15:0], data[23:16]
  input  logic [2:0]                s_tuser,     // func[2:0]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [23:0]               m_tdata,     // bus_address[15:0], bus_data[23:16]
  output logic [2:0]                m_tuser,     // kind[2:0]
  output logic                      m_tlast,
  input  logic                      cfg_wr_en,
  input  logic [pfcs_pkg::TO_W-1:0] cfg_wr_data  // poll_timeout
);
  import pfcs_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head;

  pfcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  pfcs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  pfcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_empty),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
